### sv/tree_path_max_query_macros.svh
// assertion macros shared by the path-max query block
// no dependencies
`ifndef TREE_PATH_MAX_QUERY_MACROS_SVH
`define TREE_PATH_MAX_QUERY_MACROS_SVH

// implication checked on every clock edge outside reset
`define TPMQ_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("tpmq check failed");

// implication with the consequent checked in the cycle after the antecedent
`define TPMQ_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("tpmq check failed");

`endif

### sv/tpmq_pkg.sv
// shared types and constants for the tree path-max query block
// no dependencies
`default_nettype none
package tpmq_pkg;
  localparam int unsigned DEF_MAX_NODES  = 1024;
  localparam int unsigned DEF_VALUE_BITS = 30;
  localparam int unsigned NODE_W  = 11;
  localparam int unsigned POS_W   = 10;
  localparam int unsigned DEPTH_W = 10;
  localparam int unsigned OUT_W   = 30;

  typedef enum logic [1:0] {
    REQ_LOAD  = 2'd0,
    REQ_SET   = 2'd1,
    REQ_QUERY = 2'd2,
    REQ_NONE  = 2'd3
  } req_t;

  localparam logic [0:0] REG_NODE_COUNT = 1'b0;
endpackage
`default_nettype wire

### sv/tpmq_ram.sv
// generic single-port ram with registered read
// no dependencies
`default_nettype none
module tpmq_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wdata,
  output      logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule
`default_nettype wire

### sv/tree_path_max_query.sv
// Path-maximum queries over a rooted tree with a heavy-light decomposition.
// Load requests take one node record each, set requests change a node value,
// query requests return one path_max item. Every request is handled alone by
// a sequencer around one memory access and one compare unit; in_stall is high
// until it finishes. A load writes its record and passes one gap state; a set
// reads the node record, writes the leaf, then per level up to the root reads
// both children and writes their maximum. A query fetches both end records,
// then per chain climbed reads both chain-head records and walks that chain's
// range, and ends with a walk over the last chain (up to 2*log2(2*MAX_NODES)
// cell reads per walk); the single segment-tree memory port sets the pace.
// After reset the block sweeps the segment tree to zero before the first item.
// Uses tpmq_pkg, tpmq_ram and tree_path_max_query_macros.svh.
`default_nettype none
`include "tree_path_max_query_macros.svh"
module tree_path_max_query
  import tpmq_pkg::*;
#(
  parameter int unsigned MAX_NODES  = DEF_MAX_NODES,
  parameter int unsigned VALUE_BITS = DEF_VALUE_BITS
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output      logic                 in_stall,
  input  wire logic [1:0]           in_req_type,
  input  wire logic [NODE_W-1:0]    in_node,
  input  wire logic [NODE_W-1:0]    in_other_node,
  input  wire logic [OUT_W-1:0]     in_value,
  input  wire logic [NODE_W-1:0]    in_chain_head,
  input  wire logic [NODE_W-1:0]    in_parent_node,
  input  wire logic [DEPTH_W-1:0]   in_node_depth,
  input  wire logic [POS_W-1:0]     in_position,
  output      logic                 out_valid,
  input  wire logic                 out_stall,
  output      logic [OUT_W-1:0]     out_path_max,
  input  wire logic                 cfg_psel,
  input  wire logic                 cfg_penable,
  input  wire logic                 cfg_pwrite,
  input  wire logic [2:0]           cfg_paddr,
  input  wire logic [31:0]          cfg_pwdata,
  output      logic [31:0]          cfg_prdata,
  output      logic                 cfg_pready
);
  localparam int unsigned SEG_DEPTH = 2 * MAX_NODES;
  localparam int unsigned SEG_AW    = $clog2(SEG_DEPTH);
  localparam int unsigned TBL_DEPTH = MAX_NODES + 1;
  localparam int unsigned TBL_AW    = $clog2(TBL_DEPTH);
  localparam int unsigned CW        = SEG_AW + 2;          // wide enough for any index
  localparam int unsigned STEP_W    = $clog2(2 * MAX_NODES + 1);
  localparam int unsigned REC_W     = NODE_W + NODE_W + DEPTH_W + POS_W;
  localparam logic [CW-1:0] SEG_LIM = CW'(SEG_DEPTH);
  localparam logic [NODE_W:0] TBL_LIM = (NODE_W + 1)'(MAX_NODES);

  typedef enum logic [17:0] {
    S_CLEAR = 18'd1,      S_IDLE = 18'd2,       S_LOAD = 18'd4,
    S_SREC = 18'd8,       S_SLEAF = 18'd16,     S_SUPL = 18'd32,
    S_SUPR = 18'd64,      S_SUPW = 18'd128,     S_QRU = 18'd256,
    S_QRV = 18'd512,      S_QCMP = 18'd1024,    S_QHEAD = 18'd2048,
    S_QPOS = 18'd4096,    S_RINIT = 18'd8192,   S_RHI = 18'd16384,
    S_RLO = 18'd32768,    S_RGET = 18'd65536,   S_OUT = 18'd131072
  } state_t;

  state_t state_r, state_nxt;

  // configuration
  logic [NODE_W-1:0] node_count_r;
  logic              cfg_wr;
  logic [CW-1:0]     leaf_off;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;
  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr[2] == REG_NODE_COUNT) ? {21'd0, node_count_r} : 32'd0;
  always_comb begin
    if (node_count_r == '0) leaf_off = CW'(1);
    else if ({1'b0, node_count_r} > TBL_LIM) leaf_off = CW'(MAX_NODES);
    else leaf_off = CW'(node_count_r);
  end

  // record table: head, parent, depth, pos packed in one word
  logic              rec_we;
  logic [TBL_AW-1:0] rec_addr;
  logic [REC_W-1:0]  rec_wdata, rec_rdata;
  logic [NODE_W-1:0] rec_head, rec_par;
  logic [DEPTH_W-1:0] rec_dep;
  logic [POS_W-1:0]  rec_pos;
  logic              rec_ok_r;  // read address lay inside the table
  assign {rec_head, rec_par, rec_dep, rec_pos} =
      rec_ok_r ? rec_rdata : '0;

  tpmq_ram #(.WIDTH(REC_W), .DEPTH(TBL_DEPTH)) u_rec (
    .clk(clk), .we(rec_we), .addr(rec_addr), .wdata(rec_wdata), .rdata(rec_rdata)
  );

  // segment tree
  logic              seg_we;
  logic [SEG_AW-1:0] seg_addr;
  logic [OUT_W-1:0]  seg_wdata, seg_rdata, seg_val;
  logic              seg_ok_r;
  assign seg_val = seg_ok_r ? seg_rdata : '0;

  tpmq_ram #(.WIDTH(OUT_W), .DEPTH(SEG_DEPTH)) u_seg (
    .clk(clk), .we(seg_we), .addr(seg_addr), .wdata(seg_wdata), .rdata(seg_rdata)
  );

  // working registers
  logic [NODE_W-1:0]  u_r, v_r, u_nxt, v_nxt;
  logic [OUT_W-1:0]   val_r, val_nxt, mx_r, mx_nxt, tmp_r, tmp_nxt;
  logic [NODE_W-1:0]  hu_r, hv_r, hu_nxt, hv_nxt;
  logic [NODE_W-1:0]  pu_r, pv_r, pu_nxt, pv_nxt;
  logic [DEPTH_W-1:0] du_r, dv_r, du_nxt, dv_nxt;
  logic [POS_W-1:0]   su_r, sv_r, su_nxt, sv_nxt;
  logic [DEPTH_W-1:0] dhu_r, dhv_r, dhu_nxt, dhv_nxt;
  logic [POS_W-1:0]   phu_r, phv_r, phu_nxt, phv_nxt;
  logic [CW-1:0]      idx_r, idx_nxt, lo_r, lo_nxt, hi_r, hi_nxt;
  logic [STEP_W-1:0]  steps_r, steps_nxt;
  logic [1:0]         sub_r, sub_nxt;     // record fetch phase in climb
  logic               fin_r, fin_nxt;     // final same-chain range
  logic               rlo_r, rlo_nxt;     // pending read is the low side
  logic               out_valid_r, out_valid_nxt;
  logic [OUT_W-1:0]   out_r, out_nxt;
  logic               rec_ok_nxt, seg_ok_nxt;

  logic [OUT_W-1:0] vmask;
  assign vmask = (VALUE_BITS >= OUT_W) ? '1 : OUT_W'((64'd1 << VALUE_BITS) - 64'd1);

  function automatic logic tbl_ok(input logic [NODE_W-1:0] n);
    return {1'b0, n} <= TBL_LIM;
  endfunction

  function automatic logic [OUT_W-1:0] vmax(input logic [OUT_W-1:0] a,
                                            input logic [OUT_W-1:0] b);
    return (a > b) ? a : b;
  endfunction

  logic accept;
  assign in_stall     = (state_r != S_IDLE);
  assign accept       = in_valid && !in_stall;
  assign out_valid    = out_valid_r;
  assign out_path_max = out_r;

  always_comb begin
    state_nxt = state_r;
    u_nxt = u_r;  v_nxt = v_r;  val_nxt = val_r;  mx_nxt = mx_r;  tmp_nxt = tmp_r;
    hu_nxt = hu_r; hv_nxt = hv_r; pu_nxt = pu_r; pv_nxt = pv_r;
    du_nxt = du_r; dv_nxt = dv_r; su_nxt = su_r; sv_nxt = sv_r;
    dhu_nxt = dhu_r; dhv_nxt = dhv_r; phu_nxt = phu_r; phv_nxt = phv_r;
    idx_nxt = idx_r; lo_nxt = lo_r; hi_nxt = hi_r; steps_nxt = steps_r;
    sub_nxt = sub_r; fin_nxt = fin_r; rlo_nxt = rlo_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_nxt = out_r;
    rec_we = 1'b0; rec_addr = '0; rec_wdata = '0; rec_ok_nxt = 1'b0;
    seg_we = 1'b0; seg_addr = '0; seg_wdata = '0; seg_ok_nxt = 1'b0;
    case (state_r)
      S_CLEAR: begin
        seg_we = 1'b1; seg_addr = idx_r[SEG_AW-1:0];
        idx_nxt = idx_r + CW'(1);
        if (idx_r == SEG_LIM - CW'(1)) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (accept) begin
          u_nxt = in_node; v_nxt = in_other_node; val_nxt = in_value & vmask;
          mx_nxt = '0; steps_nxt = '0; sub_nxt = '0; fin_nxt = 1'b0;
          case (req_t'(in_req_type))
            REQ_LOAD: begin
              rec_we = tbl_ok(in_node); rec_addr = TBL_AW'(in_node);
              rec_wdata = {in_chain_head, in_parent_node, in_node_depth, in_position};
              state_nxt = S_LOAD;
            end
            REQ_SET: begin
              if (tbl_ok(in_node)) begin
                rec_addr = TBL_AW'(in_node); rec_ok_nxt = 1'b1; state_nxt = S_SREC;
              end else state_nxt = S_LOAD;
            end
            REQ_QUERY: begin
              rec_addr = TBL_AW'(in_node); rec_ok_nxt = tbl_ok(in_node);
              state_nxt = S_QRU;
            end
            default: state_nxt = S_LOAD;
          endcase
        end
      end
      S_LOAD: state_nxt = S_IDLE;   // gap so a no-result item is fully retired
      S_SREC: begin
        idx_nxt = CW'(rec_pos) + leaf_off;
        state_nxt = S_SLEAF;
      end
      S_SLEAF: begin
        seg_we = (idx_r < SEG_LIM); seg_addr = idx_r[SEG_AW-1:0]; seg_wdata = val_r;
        idx_nxt = idx_r >> 1;
        seg_addr = seg_we ? idx_r[SEG_AW-1:0] : '0;
        if ((idx_r >> 1) == '0) state_nxt = S_IDLE;
        else state_nxt = S_SUPL;
      end
      S_SUPL: begin
        seg_addr = SEG_AW'({idx_r, 1'b0}); seg_ok_nxt = ({idx_r, 1'b0} < {1'b0, SEG_LIM});
        state_nxt = S_SUPR;
      end
      S_SUPR: begin
        tmp_nxt = seg_val;
        seg_addr = SEG_AW'({idx_r, 1'b1}); seg_ok_nxt = ({idx_r, 1'b1} < {1'b0, SEG_LIM});
        state_nxt = S_SUPW;
      end
      S_SUPW: begin
        seg_we = (idx_r < SEG_LIM); seg_addr = SEG_AW'(idx_r);
        seg_wdata = vmax(tmp_r, seg_val);
        idx_nxt = idx_r >> 1;
        if ((idx_r >> 1) == '0) state_nxt = S_IDLE;
        else state_nxt = S_SUPL;
      end
      S_QRU: begin
        hu_nxt = rec_head; pu_nxt = rec_par; du_nxt = rec_dep; su_nxt = rec_pos;
        rec_addr = TBL_AW'(v_r); rec_ok_nxt = tbl_ok(v_r);
        state_nxt = S_QRV;
      end
      S_QRV: begin
        hv_nxt = rec_head; pv_nxt = rec_par; dv_nxt = rec_dep; sv_nxt = rec_pos;
        state_nxt = S_QCMP;
      end
      S_QCMP: begin
        if (hu_r != hv_r && steps_r < STEP_W'(2 * MAX_NODES)) begin
          rec_addr = TBL_AW'(hu_r); rec_ok_nxt = tbl_ok(hu_r);
          sub_nxt = 2'd0; state_nxt = S_QHEAD;
        end else begin
          fin_nxt = 1'b1;
          if (du_r > dv_r) begin
            lo_nxt = CW'(sv_r) + leaf_off; hi_nxt = CW'(su_r) + leaf_off + CW'(1);
            if (su_r < sv_r) hi_nxt = lo_nxt;
          end else begin
            lo_nxt = CW'(su_r) + leaf_off; hi_nxt = CW'(sv_r) + leaf_off + CW'(1);
            if (sv_r < su_r) hi_nxt = lo_nxt;
          end
          state_nxt = S_RHI;
        end
      end
      S_QHEAD: begin
        if (sub_r == 2'd0) begin
          dhu_nxt = rec_dep; phu_nxt = rec_pos; tmp_nxt = OUT_W'(rec_par);
          rec_addr = TBL_AW'(hv_r); rec_ok_nxt = tbl_ok(hv_r);
          sub_nxt = 2'd1;
        end else begin
          dhv_nxt = rec_dep; phv_nxt = rec_pos;
          pv_nxt = rec_par; pu_nxt = NODE_W'(tmp_r);
          state_nxt = S_QPOS;
        end
      end
      S_QPOS: begin
        steps_nxt = steps_r + STEP_W'(1);
        fin_nxt = 1'b0;
        if (dhu_r > dhv_r) begin
          lo_nxt = CW'(phu_r) + leaf_off; hi_nxt = CW'(su_r) + leaf_off + CW'(1);
          if (su_r < phu_r) hi_nxt = lo_nxt;
          u_nxt = pu_r;
        end else begin
          lo_nxt = CW'(phv_r) + leaf_off; hi_nxt = CW'(sv_r) + leaf_off + CW'(1);
          if (sv_r < phv_r) hi_nxt = lo_nxt;
          v_nxt = pv_r;
        end
        state_nxt = S_RHI;
      end
      S_RHI: begin
        // one side of the walk per visit
        if (lo_r >= hi_r) begin
          if (fin_r) begin
            state_nxt = S_OUT;
          end else begin
            rec_addr = TBL_AW'(u_r); rec_ok_nxt = tbl_ok(u_r);
            state_nxt = S_QRU;
          end
        end else if (hi_r[0]) begin
          hi_nxt = hi_r - CW'(1);
          seg_addr = SEG_AW'(hi_r - CW'(1)); seg_ok_nxt = (hi_r - CW'(1)) < SEG_LIM;
          rlo_nxt = 1'b0; state_nxt = S_RGET;
        end else state_nxt = S_RLO;
      end
      S_RLO: begin
        if (lo_r[0]) begin
          lo_nxt = lo_r + CW'(1);
          seg_addr = SEG_AW'(lo_r); seg_ok_nxt = lo_r < SEG_LIM;
          rlo_nxt = 1'b1; state_nxt = S_RGET;
        end else begin
          lo_nxt = lo_r >> 1; hi_nxt = hi_r >> 1; state_nxt = S_RHI;
        end
      end
      S_RGET: begin
        mx_nxt = vmax(mx_r, seg_val);
        if (rlo_r) begin
          lo_nxt = lo_r >> 1; hi_nxt = hi_r >> 1; state_nxt = S_RHI;
        end else state_nxt = S_RLO;
      end
      S_OUT: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1; out_nxt = mx_r; state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR; node_count_r <= NODE_W'(1024); out_valid_r <= 1'b0;
      idx_r <= '0;
    end else begin
      state_r <= state_nxt; out_valid_r <= out_valid_nxt; idx_r <= idx_nxt;
      if (cfg_wr && cfg_paddr[2] == REG_NODE_COUNT) node_count_r <= cfg_pwdata[NODE_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    u_r <= u_nxt; v_r <= v_nxt; val_r <= val_nxt; mx_r <= mx_nxt; tmp_r <= tmp_nxt;
    hu_r <= hu_nxt; hv_r <= hv_nxt; pu_r <= pu_nxt; pv_r <= pv_nxt;
    du_r <= du_nxt; dv_r <= dv_nxt; su_r <= su_nxt; sv_r <= sv_nxt;
    dhu_r <= dhu_nxt; dhv_r <= dhv_nxt; phu_r <= phu_nxt; phv_r <= phv_nxt;
    lo_r <= lo_nxt; hi_r <= hi_nxt; steps_r <= steps_nxt;
    sub_r <= sub_nxt; fin_r <= fin_nxt; rlo_r <= rlo_nxt;
    out_r <= out_nxt; rec_ok_r <= rec_ok_nxt; seg_ok_r <= seg_ok_nxt;
  end

  `TPMQ_ASSERT_IMP(a_onehot, 1'b1, $onehot(state_r))
  `TPMQ_ASSERT_IMP(a_no_accept_busy, state_r != S_IDLE, !accept)
  `TPMQ_ASSERT_IMP(a_out_from_query, $rose(out_valid_r), $past(state_r, 1) == S_OUT)
  `TPMQ_ASSERT_IMP(a_no_seg_write_query, state_r == S_RGET || state_r == S_RHI, !seg_we)
endmodule
`default_nettype wire

### dv/tree_path_max_query_test.sv
// self-checking testbench for tree_path_max_query: loads random heavy-light
// decompositions, sets values, runs path-max queries against a predictor.
// depends on tpmq_pkg and the tree_path_max_query rtl
`default_nettype none
module tree_path_max_query_test;
  import tpmq_pkg::*;

  localparam int unsigned NODES   = DEF_MAX_NODES;
  localparam int unsigned SEG_LEN = 2 * NODES;
  localparam int unsigned STALL_LIMIT = 200000;

  class path_max_scoreboard;
    bit [OUT_W-1:0]   seg[SEG_LEN];
    bit [POS_W-1:0]   pos_of[NODES+1];
    bit [NODE_W-1:0]  head_of[NODES+1];
    bit [NODE_W-1:0]  parent_of[NODES+1];
    bit [DEPTH_W-1:0] depth_of[NODES+1];
    bit [NODE_W-1:0]  node_count;
    bit [OUT_W-1:0]   expected_max[$];
    int unsigned      errors;

    function new();
      foreach (seg[i]) seg[i] = '0;
      foreach (pos_of[i]) begin
        pos_of[i] = '0;
        head_of[i] = '0;
        parent_of[i] = '0;
        depth_of[i] = '0;
      end
      node_count = NODE_W'(NODES);
      errors = 0;
    endfunction

    function void set_node_count(bit [31:0] v);
      node_count = v[NODE_W-1:0];
    endfunction

    function int unsigned offset();
      if (node_count == 0) return 1;
      if (node_count > NODES) return NODES;
      return node_count;
    endfunction

    function int unsigned seg_rd(int unsigned idx);
      return idx < SEG_LEN ? seg[idx] : 0;
    endfunction

    function int unsigned rec(int which, int unsigned n);
      if (n > NODES) return 0;
      case (which)
        0: return pos_of[n];
        1: return head_of[n];
        2: return parent_of[n];
        default: return depth_of[n];
      endcase
    endfunction

    function int unsigned umax(int unsigned a, int unsigned b);
      return a > b ? a : b;
    endfunction

    function void write_leaf(int unsigned p, int unsigned v);
      int unsigned idx;
      idx = p + offset();
      if (idx < SEG_LEN) seg[idx] = v[OUT_W-1:0];
      for (idx = idx >> 1; idx != 0; idx = idx >> 1)
        if (idx < SEG_LEN) seg[idx] = OUT_W'(umax(seg_rd(2*idx), seg_rd(2*idx+1)));
    endfunction

    function int unsigned span_max(int unsigned l, int unsigned r);
      int unsigned lo, hi, mx;
      mx = 0;
      if (r < l) return 0;
      lo = l + offset();
      hi = r + offset() + 1;
      while (lo < hi) begin
        if (hi & 1) begin
          hi--;
          mx = umax(mx, seg_rd(hi));
        end
        if (lo & 1) begin
          mx = umax(mx, seg_rd(lo));
          lo++;
        end
        lo = lo >> 1;
        hi = hi >> 1;
      end
      return mx;
    endfunction

    function int unsigned climb_max(int unsigned u, int unsigned v);
      int unsigned mx, steps, hu, hv, t;
      mx = 0;
      steps = 0;
      while (rec(1, u) != rec(1, v) && steps < 2*NODES) begin
        hu = rec(1, u);
        hv = rec(1, v);
        if (rec(3, hu) > rec(3, hv)) begin
          mx = umax(mx, span_max(rec(0, hu), rec(0, u)));
          u = rec(2, hu);
        end else begin
          mx = umax(mx, span_max(rec(0, hv), rec(0, v)));
          v = rec(2, hv);
        end
        steps++;
      end
      if (rec(3, u) > rec(3, v)) begin
        t = u;
        u = v;
        v = t;
      end
      return umax(mx, span_max(rec(0, u), rec(0, v)));
    endfunction

    function void note_item(req_t r, int unsigned n, int unsigned o, bit [OUT_W-1:0] val,
                            int unsigned hd, int unsigned par, int unsigned dep,
                            int unsigned p);
      case (r)
        REQ_LOAD: if (n <= NODES) begin
          head_of[n] = NODE_W'(hd);
          parent_of[n] = NODE_W'(par);
          depth_of[n] = DEPTH_W'(dep);
          pos_of[n] = POS_W'(p);
        end
        REQ_SET: if (n <= NODES) write_leaf(pos_of[n], val);
        REQ_QUERY: expected_max = {expected_max, OUT_W'(climb_max(n, o))};
        default: ;
      endcase
    endfunction

    function void check_result(bit [OUT_W-1:0] got);
      bit [OUT_W-1:0] want;
      if (expected_max.size() == 0) begin
        $error("unexpected path_max item, actual %0d", got);
        errors++;
        return;
      end
      want = expected_max.pop_front();
      if (got !== want) begin
        $error("path_max mismatch: expected %0d actual %0d", want, got);
        errors++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [1:0] in_req_type = REQ_LOAD;
  logic [NODE_W-1:0] in_node = '0, in_other_node = '0, in_chain_head = '0;
  logic [NODE_W-1:0] in_parent_node = '0;
  logic [OUT_W-1:0] in_value = '0;
  logic [DEPTH_W-1:0] in_node_depth = '0;
  logic [POS_W-1:0] in_position = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [OUT_W-1:0] out_path_max;
  logic cfg_psel = 1'b0, cfg_penable = 1'b0, cfg_pwrite = 1'b0;
  logic [2:0] cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic cfg_pready;

  path_max_scoreboard sb = new();
  bit calm = 1'b0;
  int unsigned idle_cycles = 0;

  // tree built in label space 1..tree_n, mapped to node ids
  int unsigned tree_n;
  int unsigned id_of[NODES+1];
  int unsigned lab_par[NODES+1], lab_depth[NODES+1], lab_head[NODES+1], lab_pos[NODES+1];
  int unsigned first_kid[NODES+1], next_sib[NODES+1];

  tree_path_max_query dut (.*);

  always #5 clk = ~clk;

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) sb.check_result(out_path_max);
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_psel)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("tree_path_max_query_test NOT OK");
      $finish;
    end
  end

  // receiver stalls in bursts
  initial begin
    int unsigned k;
    forever begin
      @(negedge clk);
      if (!calm && $urandom_range(0, 7) == 0) begin
        k = $urandom_range(1, 6);
        out_stall <= 1'b1;
        repeat (k) @(negedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  task automatic cfg_write(bit [31:0] data);
    cfg_psel <= 1'b1;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= 3'(REG_NODE_COUNT) << 2;
    cfg_pwdata <= data;
    @(negedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    sb.set_node_count(data);
    @(negedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
  endtask

  // valid stays high between back-to-back items; drain() drops it
  task automatic send(req_t r, int unsigned n, int unsigned o, bit [OUT_W-1:0] val,
                      int unsigned hd = 0, int unsigned par = 0, int unsigned dep = 0,
                      int unsigned p = 0);
    int unsigned k;
    k = 0;
    if (!calm && $urandom_range(0, 6) == 0) k = $urandom_range(1, 6);
    if (k != 0) begin
      in_valid <= 1'b0;
      repeat (k) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_req_type <= r;
    in_node <= NODE_W'(n);
    in_other_node <= NODE_W'(o);
    in_value <= val;
    in_chain_head <= NODE_W'(hd);
    in_parent_node <= NODE_W'(par);
    in_node_depth <= DEPTH_W'(dep);
    in_position <= POS_W'(p);
    do @(posedge clk); while (in_stall);
    sb.note_item(r, n, o, val, hd, par, dep, p);
    @(negedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    do @(negedge clk); while (sb.expected_max.size() != 0);
  endtask

  // quiet block between phases: sets produce no item, so allow them to finish
  task automatic settle();
    drain();
    repeat (300) @(negedge clk);
  endtask

  // random tree, first child continues the parent's chain, dfs positions
  task automatic build_tree(int unsigned n, bit use_top_id, int unsigned pbase,
                            int unsigned dbase);
    bit used[NODES+1];
    int unsigned stack[$];
    int unsigned cur, c, cnt, kids[$];
    tree_n = n;
    foreach (used[i]) used[i] = 1'b0;
    for (int unsigned i = 1; i <= n; i++) begin
      do id_of[i] = $urandom_range(1, NODES); while (used[id_of[i]]);
      used[id_of[i]] = 1'b1;
      first_kid[i] = 0;
      next_sib[i] = 0;
    end
    if (use_top_id && !used[NODES]) id_of[n] = NODES;
    lab_par[1] = 0;
    lab_depth[1] = 0;
    for (int unsigned i = 2; i <= n; i++) begin
      lab_par[i] = $urandom_range(1, i - 1);
      lab_depth[i] = lab_depth[lab_par[i]] + 1;
    end
    for (int unsigned i = n; i >= 2; i--) begin
      next_sib[i] = first_kid[lab_par[i]];
      first_kid[lab_par[i]] = i;
    end
    lab_head[1] = 1;
    for (int unsigned i = 2; i <= n; i++)
      lab_head[i] = (first_kid[lab_par[i]] == i) ? lab_head[lab_par[i]] : i;
    cnt = 0;
    stack = {stack, 1};
    while (stack.size() != 0) begin
      cur = stack.pop_back();
      lab_pos[cur] = pbase + cnt;
      cnt++;
      kids.delete();
      for (c = first_kid[cur]; c != 0; c = next_sib[c]) kids = {kids, c};
      for (int i = kids.size() - 1; i >= 0; i--) stack = {stack, kids[i]};
    end
    for (int unsigned i = 1; i <= n; i++)
      send(REQ_LOAD, id_of[i], 0, '0, id_of[lab_head[i]],
           lab_par[i] == 0 ? 0 : id_of[lab_par[i]], dbase + lab_depth[i], lab_pos[i]);
  endtask

  function automatic bit [OUT_W-1:0] rand_value();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      default: return OUT_W'($urandom);
    endcase
  endfunction

  task automatic run_phase(bit [31:0] nc, int unsigned count, int unsigned n);
    settle();
    cfg_write(nc);
    build_tree(n, 1'($urandom_range(0, 1)), $urandom_range(0, 1024 - n), 0);
    for (int unsigned k = 0; k < count; k++) begin
      if (k == count / 2 && $urandom_range(0, 1)) drain();
      if ($urandom_range(0, 9) < 4)
        send(REQ_SET, id_of[$urandom_range(1, n)], 0, rand_value());
      else
        send(REQ_QUERY, id_of[$urandom_range(1, n)], id_of[$urandom_range(1, n)], '0);
    end
  endtask

  initial begin
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed: top positions and depths, node id 1024, value extremes
    build_tree(8, 1'b1, 1016, 1016);
    send(REQ_SET, id_of[8], 0, '1);
    send(REQ_SET, id_of[1], 0, '0);
    for (int unsigned i = 2; i <= 7; i++) send(REQ_SET, id_of[i], 0, OUT_W'(i * 1000));
    send(REQ_QUERY, id_of[8], id_of[8], '0);
    send(REQ_QUERY, id_of[1], id_of[1], '0);
    send(REQ_QUERY, id_of[1], id_of[8], '0);
    send(REQ_QUERY, id_of[7], id_of[8], '0);
    send(REQ_QUERY, id_of[3], id_of[6], '0);
    send(REQ_SET, id_of[8], 0, '0);
    send(REQ_QUERY, id_of[8], id_of[2], '0);
    send(REQ_QUERY, id_of[5], id_of[4], '0);

    run_phase(1, 50, 12);
    run_phase(NODES, 60, 40);
    run_phase($urandom_range(2, NODES - 1), 60, 30);
    run_phase($urandom_range(2, 64), 50, 25);
    calm = 1'b1;
    run_phase(NODES, 40, 30);

    drain();
    repeat (300) @(posedge clk);
    if (sb.errors == 0 && sb.expected_max.size() == 0)
      $display("tree_path_max_query_test OK");
    else
      $display("tree_path_max_query_test NOT OK");
    $finish;
  end
endmodule
`default_nettype wire

### sim.f
+incdir+sv
sv/tpmq_pkg.sv
sv/tpmq_ram.sv
sv/tree_path_max_query.sv
dv/tree_path_max_query_test.sv
